@@ hdl/mlfq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_pkg
// Types and constants shared by the feedback queue scheduler modules.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam int MAX_PROCS  = 64;
    localparam int PIDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W      = PIDX_W + 1;
    localparam int MAX_LEVELS = 8;
    localparam int LVL_W      = $clog2(MAX_LEVELS);
    localparam int LNUM_W     = 4;
    localparam int VAL_W      = 16;
    localparam int TIME_W     = 24;
    localparam int LQ_DEPTH   = MAX_LEVELS * MAX_PROCS;
    localparam int LQ_AW      = $clog2(LQ_DEPTH);
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE        = 2'd2;

    typedef enum logic {CMD_LOAD, CMD_RUN} t_cmd;

    typedef struct packed {
        logic             mode;
        logic [VAL_W-1:0] arrival;
        logic [VAL_W-1:0] duration;
        logic [VAL_W-1:0] demand;
    } t_in_item;

    typedef struct packed {
        logic [PIDX_W-1:0] proc_index;
        logic [VAL_W-1:0]  arrived_at;
        logic [TIME_W-1:0] started_at;
        logic [TIME_W-1:0] completion;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [VAL_W-1:0]  boost_period;
        logic [LNUM_W-1:0] levels_in_use;
        logic [VAL_W-1:0]  slice_length;
    } t_cfg;

    typedef struct packed {
        t_cmd             cmd;
        logic [VAL_W-1:0] arrival;
        logic [VAL_W-1:0] duration;
        logic [VAL_W-1:0] demand;
    } t_job;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] loaded;
    } t_eng_stat;

    typedef struct packed {
        logic [VAL_W-1:0]  remaining;
        logic [VAL_W-1:0]  demand;
        logic              started;
        logic [TIME_W-1:0] started_at;
    } t_pstate;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_BOOST, ST_BOOST_W, ST_ADM, ST_ADM_R,
        ST_SEL, ST_POP, ST_DISP, ST_PUSH, ST_DONE
    } t_eng_state;

endpackage
`default_nettype wire

@@ hdl/mlfq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ hdl/mlfq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_front
// Accepts input beats, decodes the mode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mlfq_front
    import mlfq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_job_valid,
    output t_job          o_job,
    input  wire logic     i_job_pop
);

    t_job       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;
    t_job       job_in;

    assign o_stall     = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign push        = i_valid && !o_stall;
    assign pop         = i_job_pop && o_job_valid;

    always_comb begin
        job_in.cmd      = i_item.mode ? CMD_RUN : CMD_LOAD;
        job_in.arrival  = i_item.arrival;
        job_in.duration = i_item.duration;
        job_in.demand   = i_item.demand;
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job_in;
        end
    end

endmodule
`default_nettype wire

@@ hdl/mlfq_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_engine
// Keeps the process table and the level queues, and steps the schedule.
// ----------------------------------------------------------------------------
module mlfq_engine
    import mlfq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  wire logic i_out_stall,
    output t_eng_stat o_stat
);

    t_eng_state        r_state, n_state;
    logic [CNT_W-1:0]  r_loaded, n_loaded;
    logic [CNT_W-1:0]  r_next, n_next;
    logic [TIME_W-1:0] r_sim, n_sim;
    logic [TIME_W-1:0] r_since, n_since;
    logic [LNUM_W-1:0] r_nlev, n_nlev;
    logic [VAL_W-1:0]  r_slice, n_slice;
    logic [PIDX_W-1:0] r_head [MAX_LEVELS];
    logic [PIDX_W-1:0] n_head [MAX_LEVELS];
    logic [CNT_W-1:0]  r_cnt [MAX_LEVELS];
    logic [CNT_W-1:0]  n_cnt [MAX_LEVELS];
    logic [LVL_W:0]    r_lv, n_lv;
    logic [PIDX_W-1:0] r_p, n_p;
    logic [VAL_W-1:0]  r_next_arr, n_next_arr;
    logic              r_pend_valid, n_pend_valid;
    t_out_item         r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              lq_we;
    logic [LQ_AW-1:0]  lq_waddr, lq_raddr;
    logic [PIDX_W-1:0] lq_wdata, lq_rdata;
    logic              pa_we;
    logic [PIDX_W-1:0] pa_waddr, pa_raddr;
    logic [VAL_W-1:0]  pa_wdata, pa_rdata;
    logic              pb_we;
    logic [PIDX_W-1:0] pb_waddr, pb_raddr;
    t_pstate           pb_wdata, pb_rdata;
    logic              pc_we;
    logic [PIDX_W-1:0] pc_waddr, pc_raddr;
    logic [VAL_W-1:0]  pc_wdata, pc_rdata;

    logic              out_free;
    logic              queued, found;
    logic [LVL_W-1:0]  top, lv_sel;
    logic [PIDX_W-1:0] tail_sel, tail0;
    logic [VAL_W-1:0]  dem, used, nsl;
    logic [TIME_W-1:0] first;
    logic              finished;

    mlfq_ram #(.WIDTH(PIDX_W), .DEPTH(LQ_DEPTH)) u_lq (
        .i_clk(i_clk), .i_we(lq_we), .i_waddr(lq_waddr), .i_wdata(lq_wdata),
        .i_raddr(lq_raddr), .o_rdata(lq_rdata)
    );
    mlfq_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PROCS)) u_arr (
        .i_clk(i_clk), .i_we(pa_we), .i_waddr(pa_waddr), .i_wdata(pa_wdata),
        .i_raddr(pa_raddr), .o_rdata(pa_rdata)
    );
    mlfq_ram #(.WIDTH($bits(t_pstate)), .DEPTH(MAX_PROCS)) u_pst (
        .i_clk(i_clk), .i_we(pb_we), .i_waddr(pb_waddr), .i_wdata(pb_wdata),
        .i_raddr(pb_raddr), .o_rdata(pb_rdata)
    );
    mlfq_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PROCS)) u_slc (
        .i_clk(i_clk), .i_we(pc_we), .i_waddr(pc_waddr), .i_wdata(pc_wdata),
        .i_raddr(pc_raddr), .o_rdata(pc_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_stat      = '{busy: (r_state != ST_IDLE), loaded: r_loaded};
    assign out_free    = !r_out_valid || !i_out_stall;

    // Lowest-numbered non-empty level; levels at or above the count in use stay empty.
    always_comb begin
        top    = '0;
        found  = 1'b0;
        queued = 1'b0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
            if (r_cnt[i] != '0) begin
                top    = LVL_W'(i);
                found  = 1'b1;
                queued = 1'b1;
            end
        end
    end

    assign lv_sel   = (r_state == ST_SEL) ? top : r_lv[LVL_W-1:0];
    assign tail_sel = r_head[lv_sel] + r_cnt[lv_sel][PIDX_W-1:0];
    assign tail0    = r_head[0] + r_cnt[0][PIDX_W-1:0];

    // Dispatch arithmetic on the entry fetched for the popped process.
    always_comb begin
        first = pb_rdata.started ? pb_rdata.started_at : r_sim;
        dem   = (pb_rdata.demand == '0) ? VAL_W'(1) : pb_rdata.demand;
        if (pc_rdata < dem) begin
            used = pc_rdata;
            nsl  = '0;
        end else begin
            used = dem;
            nsl  = pc_rdata - dem;
        end
        finished = !(pb_rdata.remaining > used);
    end

    always_comb begin
        n_state      = r_state;
        n_loaded     = r_loaded;
        n_next       = r_next;
        n_sim        = r_sim;
        n_since      = r_since;
        n_nlev       = r_nlev;
        n_slice      = r_slice;
        n_head       = r_head;
        n_cnt        = r_cnt;
        n_lv         = r_lv;
        n_p          = r_p;
        n_next_arr   = r_next_arr;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        o_job_pop    = 1'b0;
        lq_we        = 1'b0;
        lq_waddr     = {LVL_W'(0), tail0};
        lq_wdata     = lq_rdata;
        lq_raddr     = {lv_sel, r_head[lv_sel]};
        pa_we        = 1'b0;
        pa_waddr     = r_loaded[PIDX_W-1:0];
        pa_wdata     = i_job.arrival;
        pa_raddr     = r_p;
        pb_we        = 1'b0;
        pb_waddr     = r_loaded[PIDX_W-1:0];
        pb_wdata     = '{remaining: i_job.duration, demand: i_job.demand,
                         started: 1'b0, started_at: '0};
        pb_raddr     = (r_state == ST_POP) ? lq_rdata : r_p;
        pc_we        = 1'b0;
        pc_waddr     = r_next[PIDX_W-1:0];
        pc_wdata     = r_slice;
        pc_raddr     = (r_state == ST_POP) ? lq_rdata : r_p;

        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.cmd == CMD_LOAD) begin
                        o_job_pop = 1'b1;
                        if (r_loaded < CNT_W'(MAX_PROCS)) begin
                            pa_we    = 1'b1;
                            pb_we    = 1'b1;
                            n_loaded = r_loaded + CNT_W'(1);
                        end
                    end else begin
                        if (i_cfg.levels_in_use == '0) begin
                            n_nlev = LNUM_W'(1);
                        end else if (i_cfg.levels_in_use > LNUM_W'(MAX_LEVELS)) begin
                            n_nlev = LNUM_W'(MAX_LEVELS);
                        end else begin
                            n_nlev = i_cfg.levels_in_use;
                        end
                        n_slice = (i_cfg.slice_length == '0) ? VAL_W'(1)
                                                             : i_cfg.slice_length;
                        for (int i = 0; i < MAX_LEVELS; i++) begin
                            n_head[i] = '0;
                            n_cnt[i]  = '0;
                        end
                        n_sim        = '0;
                        n_since      = '0;
                        n_next       = '0;
                        n_pend_valid = 1'b0;
                        n_state      = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (r_next >= r_loaded && !queued) begin
                    n_state = ST_DONE;
                end else if ({8'd0, i_cfg.boost_period} <= r_since) begin
                    n_since = '0;
                    n_lv    = (LVL_W + 1)'(1);
                    n_state = ST_BOOST;
                end else begin
                    n_state = ST_ADM;
                end
            end
            ST_BOOST: begin
                if ({{(LNUM_W - LVL_W - 1){1'b0}}, r_lv} >= r_nlev) begin
                    n_state = ST_ADM;
                end else if (r_cnt[lv_sel] == '0) begin
                    n_lv = r_lv + (LVL_W + 1)'(1);
                end else begin
                    n_head[lv_sel] = r_head[lv_sel] + PIDX_W'(1);
                    n_cnt[lv_sel]  = r_cnt[lv_sel] - CNT_W'(1);
                    n_state        = ST_BOOST_W;
                end
            end
            ST_BOOST_W: begin
                lq_we    = 1'b1;
                n_cnt[0] = r_cnt[0] + CNT_W'(1);
                n_state  = ST_BOOST;
            end
            ST_ADM: begin
                pa_raddr = r_next[PIDX_W-1:0];
                n_state  = (r_next < r_loaded) ? ST_ADM_R : ST_SEL;
            end
            ST_ADM_R: begin
                if ({8'd0, pa_rdata} <= r_sim) begin
                    pc_we    = 1'b1;
                    lq_we    = 1'b1;
                    lq_wdata = r_next[PIDX_W-1:0];
                    n_cnt[0] = r_cnt[0] + CNT_W'(1);
                    n_next   = r_next + CNT_W'(1);
                    n_state  = ST_ADM;
                end else begin
                    n_next_arr = pa_rdata;
                    n_state    = ST_SEL;
                end
            end
            ST_SEL: begin
                if (!found) begin
                    // Nothing ready: jump straight to the next arrival.
                    if (r_next < r_loaded) begin
                        n_since = r_since + ({8'd0, r_next_arr} - r_sim);
                        n_sim   = {8'd0, r_next_arr};
                    end
                    n_state = ST_CHECK;
                end else begin
                    n_head[lv_sel] = r_head[lv_sel] + PIDX_W'(1);
                    n_cnt[lv_sel]  = r_cnt[lv_sel] - CNT_W'(1);
                    n_lv           = {1'b0, top};
                    n_state        = ST_POP;
                end
            end
            ST_POP: begin
                n_p      = lq_rdata;
                pa_raddr = lq_rdata;
                n_state  = ST_DISP;
            end
            ST_DISP: begin
                pb_waddr = r_p;
                pc_waddr = r_p;
                if (finished) begin
                    // Completions are held back one place so the last can be flagged.
                    if (!r_pend_valid || out_free) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                        end
                        n_pend_valid = 1'b1;
                        n_pend = '{proc_index: r_p, arrived_at: pa_rdata,
                                   started_at: first,
                                   completion: r_sim + {8'd0, pb_rdata.remaining},
                                   last: 1'b0};
                        n_sim   = r_sim + {8'd0, used};
                        n_since = r_since + {8'd0, used};
                        n_state = ST_CHECK;
                    end
                end else begin
                    pb_we    = 1'b1;
                    pb_wdata = '{remaining: pb_rdata.remaining - used,
                                 demand: pb_rdata.demand, started: 1'b1,
                                 started_at: first};
                    pc_we    = 1'b1;
                    if (nsl == '0) begin
                        pc_wdata = r_slice;
                        if ({{(LNUM_W - LVL_W - 1){1'b0}}, r_lv} + LNUM_W'(1) < r_nlev) begin
                            n_lv = r_lv + (LVL_W + 1)'(1);
                        end
                    end else begin
                        pc_wdata = nsl;
                    end
                    n_sim   = r_sim + {8'd0, used};
                    n_since = r_since + {8'd0, used};
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                lq_we          = 1'b1;
                lq_waddr       = {lv_sel, tail_sel};
                lq_wdata       = r_p;
                n_cnt[lv_sel]  = r_cnt[lv_sel] + CNT_W'(1);
                n_state        = ST_CHECK;
            end
            ST_DONE: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = r_pend;
                        n_out.last  = 1'b1;
                    end
                    n_pend_valid = 1'b0;
                    n_loaded     = '0;
                    n_sim        = '0;
                    n_since      = '0;
                    o_job_pop    = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_loaded     <= '0;
            r_next       <= '0;
            r_sim        <= '0;
            r_since      <= '0;
            r_nlev       <= LNUM_W'(1);
            r_slice      <= VAL_W'(1);
            r_lv         <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_loaded     <= n_loaded;
            r_next       <= n_next;
            r_sim        <= n_sim;
            r_since      <= n_since;
            r_nlev       <= n_nlev;
            r_slice      <= n_slice;
            r_lv         <= n_lv;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_head       <= n_head;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_next_arr <= n_next_arr;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

endmodule
`default_nettype wire

@@ hdl/mlfq_scheduler_sim_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_scheduler_sim_core
// Multilevel feedback queue scheduler simulation, top level.
// ----------------------------------------------------------------------------
// Load beats fill the process table at one beat per cycle while no run is in
// progress. A run beat then steps the schedule in a sequencer that owns the
// process table and one level-queue memory, each with a single read port:
// admitting a process reads its arrival, then queues it at level 0; a boost
// moves processes one by one into level 0, scanning the levels; a dispatch
// pops a process, reads its state and runs it (after an admission check while
// records are still to arrive, and a push when it goes back into a queue),
// and waits while a completion meets a stalled output. Completions leave in
// completion order, the final one of a run marked by last, through an output
// register, while a two-entry queue in front holds up to two waiting beats.
module mlfq_scheduler_sim_core
    import mlfq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [VAL_W-1:0]     i_cfg_data
);

    t_cfg      r_cfg;
    logic      job_valid, job_pop;
    t_job      job;
    t_eng_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.boost_period  <= VAL_W'(100);
            r_cfg.levels_in_use <= LNUM_W'(3);
            r_cfg.slice_length  <= VAL_W'(10);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BOOST_PERIOD) begin
                r_cfg.boost_period <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_LEVELS) begin
                r_cfg.levels_in_use <= i_cfg_data[LNUM_W-1:0];
            end
            if (i_cfg_idx == CFG_SLICE) begin
                r_cfg.slice_length <= i_cfg_data;
            end
        end
    end

    mlfq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_item     (i_in_data),
        .o_job_valid(job_valid),
        .o_job      (job),
        .i_job_pop  (job_pop)
    );

    mlfq_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_job_valid(job_valid),
        .i_job      (job),
        .o_job_pop  (job_pop),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_data),
        .i_out_stall(i_out_stall),
        .o_stat     (stat)
    );

    a_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_table_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.loaded <= CNT_W'(MAX_PROCS))
        else $error("process table count beyond capacity");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> job_valid)
        else $error("engine took a beat from an empty queue");

endmodule
`default_nettype wire
